[sv/shape_overlap_tester_unit_macros.svh]
// ----------------------------------------------------------------------------
// Shape overlap tester assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SHAPE_OVERLAP_TESTER_UNIT_MACROS_SVH
`define SHAPE_OVERLAP_TESTER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent match.
`define SOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent match.
`define SOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sot_pkg.sv]
// ----------------------------------------------------------------------------
// Shape overlap tester package
// Operation codes and stream field layout shared by the block and its checker.
// ----------------------------------------------------------------------------
package sot_pkg;

    // operation codes (carried on s_tuser)
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_CIRC_CIRC = 3'd0;
    localparam logic [OP_W-1:0] OP_RECT_RECT = 3'd1;
    localparam logic [OP_W-1:0] OP_CIRC_RECT = 3'd2;
    localparam logic [OP_W-1:0] OP_PT_CIRC   = 3'd3;
    localparam logic [OP_W-1:0] OP_PT_RECT   = 3'd4;
    localparam logic [OP_W-1:0] OP_BLK_CIRC  = 3'd5;
    localparam logic [OP_W-1:0] OP_BLK_RECT  = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE      = 3'd7;

    // field widths
    localparam int COORD_W = 20;   // signed Q16.4
    localparam int SIZE_W  = 19;   // unsigned Q15.4

    // input tdata layout, lowest field first
    localparam int A_X_LSB      = 0;
    localparam int A_Y_LSB      = A_X_LSB + COORD_W;
    localparam int A_RADIUS_LSB = A_Y_LSB + COORD_W;
    localparam int A_WIDTH_LSB  = A_RADIUS_LSB + SIZE_W;
    localparam int A_HEIGHT_LSB = A_WIDTH_LSB + SIZE_W;
    localparam int B_X_LSB      = A_HEIGHT_LSB + SIZE_W;
    localparam int B_Y_LSB      = B_X_LSB + COORD_W;
    localparam int B_RADIUS_LSB = B_Y_LSB + COORD_W;
    localparam int B_WIDTH_LSB  = B_RADIUS_LSB + SIZE_W;
    localparam int B_HEIGHT_LSB = B_WIDTH_LSB + SIZE_W;
    localparam int IN_FIELDS_W  = B_HEIGHT_LSB + SIZE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // output tdata layout
    localparam int HIT_BIT     = 0;
    localparam int OUT_TDATA_W = 8;

    // internal arithmetic widths
    localparam int EXT_W  = COORD_W + 2;   // corner plus size, and differences
    localparam int MAG_W  = EXT_W - 1;     // absolute distance along one axis
    localparam int RAD_W  = SIZE_W + 1;    // sum of two radii
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int RSQ_W  = 2 * RAD_W;

endpackage

[sv/shape_overlap_tester_unit.sv]
// ----------------------------------------------------------------------------
// Shape overlap tester
// One geometric hit test per beat: circle, rectangle, point and block tests.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                          | tuser
//  s_*     | in        | a_x..b_height, 194 bits packed | operation (3 bits)
//  m_*     | out       | hit in bit 0                   | -
//
//  One beat per cycle sustained while m_tready is high; an input beat passes the
//  input register and the result register, around the test logic, to its result beat.
//  The test logic is one squared-distance unit (two axis squares and a radius
//  square) plus the rectangle comparators.
//  rst_n clears both valid flags; data registers are not reset.
//  A stall on m_tready holds the result and backs up into s_tready only once
//  both registers are full.
// ----------------------------------------------------------------------------
module shape_overlap_tester_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_x, a_y, a_radius, a_width, a_height, b_x, b_y, b_radius, b_width,
    // b_height, zero pad
    input  logic [sot_pkg::IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [sot_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, zero pad
    output logic [sot_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int CW = sot_pkg::COORD_W;
    localparam int SW = sot_pkg::SIZE_W;
    localparam int EW = sot_pkg::EXT_W;
    localparam int MW = sot_pkg::MAG_W;
    localparam int RW = sot_pkg::RAD_W;

    // input register
    logic                       in_valid_reg;
    logic [sot_pkg::OP_W-1:0]   op_reg;
    logic signed [CW-1:0]       a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic [SW-1:0]              a_radius_reg, a_width_reg, a_height_reg;
    logic [SW-1:0]              b_radius_reg, b_width_reg, b_height_reg;

    // result register
    logic                       out_valid_reg;
    logic                       hit_reg;
    logic                       hit_next;

    logic                       advance;

    // extended coordinates
    logic signed [EW-1:0]       ax, ay, bx, by, aw, ah, bw, bh;
    logic signed [EW-1:0]       axw, ayh, bxw, byh;

    logic [MW-1:0]              dx_mag, dy_mag;
    logic [RW-1:0]              rad;
    logic [sot_pkg::SQ_W-1:0]   dx_sq, dy_sq;
    logic [sot_pkg::DIST_W-1:0] dist_sq;
    logic [sot_pkg::RSQ_W-1:0]  rad_sq;
    logic                       circle_hit, rect_hit, point_hit, block_hit;

    function automatic logic [MW-1:0] abs_mag(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] n;
        n = -v;
        return v[EW-1] ? n[MW-1:0] : v[MW-1:0];
    endfunction

    function automatic logic [MW-1:0] max_mag(input logic [MW-1:0] p,
                                              input logic [MW-1:0] q);
        return (p > q) ? p : q;
    endfunction

    // distance from a to the span [lo, hi], zero when inside
    function automatic logic [MW-1:0] clamp_mag(input logic signed [EW-1:0] a,
                                                input logic signed [EW-1:0] lo,
                                                input logic signed [EW-1:0] hi);
        logic signed [EW-1:0] below;
        logic signed [EW-1:0] above;
        below = lo - a;
        above = a - hi;
        if (a < lo)
        begin
            return below[MW-1:0];
        end
        else if (a > hi)
        begin
            return above[MW-1:0];
        end
        return '0;
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg       <= s_tuser;
            a_x_reg      <= s_tdata[sot_pkg::A_X_LSB +: CW];
            a_y_reg      <= s_tdata[sot_pkg::A_Y_LSB +: CW];
            a_radius_reg <= s_tdata[sot_pkg::A_RADIUS_LSB +: SW];
            a_width_reg  <= s_tdata[sot_pkg::A_WIDTH_LSB +: SW];
            a_height_reg <= s_tdata[sot_pkg::A_HEIGHT_LSB +: SW];
            b_x_reg      <= s_tdata[sot_pkg::B_X_LSB +: CW];
            b_y_reg      <= s_tdata[sot_pkg::B_Y_LSB +: CW];
            b_radius_reg <= s_tdata[sot_pkg::B_RADIUS_LSB +: SW];
            b_width_reg  <= s_tdata[sot_pkg::B_WIDTH_LSB +: SW];
            b_height_reg <= s_tdata[sot_pkg::B_HEIGHT_LSB +: SW];
        end
        if (advance && in_valid_reg)
        begin
            hit_reg <= hit_next;
        end
    end

    assign ax = EW'(a_x_reg);
    assign ay = EW'(a_y_reg);
    assign bx = EW'(b_x_reg);
    assign by = EW'(b_y_reg);
    assign aw = {{(EW-SW){1'b0}}, a_width_reg};
    assign ah = {{(EW-SW){1'b0}}, a_height_reg};
    assign bw = {{(EW-SW){1'b0}}, b_width_reg};
    assign bh = {{(EW-SW){1'b0}}, b_height_reg};

    assign axw = ax + aw;
    assign ayh = ay + ah;
    assign bxw = bx + bw;
    assign byh = by + bh;

    // Pick the per-axis distances and radius for the circle tests. For a block
    // the farthest corner decides, and it is the farthest edge on each axis.
    always_comb
    begin
        dx_mag = '0;
        dy_mag = '0;
        rad    = '0;
        case (op_reg)
            sot_pkg::OP_CIRC_CIRC:
            begin
                dx_mag = abs_mag(ax - bx);
                dy_mag = abs_mag(ay - by);
                rad    = {1'b0, a_radius_reg} + {1'b0, b_radius_reg};
            end
            sot_pkg::OP_CIRC_RECT:
            begin
                dx_mag = clamp_mag(ax, bx, bxw);
                dy_mag = clamp_mag(ay, by, byh);
                rad    = {1'b0, a_radius_reg};
            end
            sot_pkg::OP_PT_CIRC:
            begin
                dx_mag = abs_mag(ax - bx);
                dy_mag = abs_mag(ay - by);
                rad    = {1'b0, b_radius_reg};
            end
            sot_pkg::OP_BLK_CIRC:
            begin
                dx_mag = max_mag(abs_mag(ax - bx), abs_mag(axw - bx));
                dy_mag = max_mag(abs_mag(ay - by), abs_mag(ayh - by));
                rad    = {1'b0, b_radius_reg};
            end
            default:
            begin
                dx_mag = '0;
                dy_mag = '0;
                rad    = '0;
            end
        endcase
    end

    assign dx_sq   = sot_pkg::SQ_W'(dx_mag) * sot_pkg::SQ_W'(dx_mag);
    assign dy_sq   = sot_pkg::SQ_W'(dy_mag) * sot_pkg::SQ_W'(dy_mag);
    assign rad_sq  = sot_pkg::RSQ_W'(rad) * sot_pkg::RSQ_W'(rad);
    assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};

    assign circle_hit = dist_sq <= sot_pkg::DIST_W'(rad_sq);
    assign rect_hit   = (ax <= bxw) && (ay <= byh) && (axw >= bx) && (ayh >= by);
    assign point_hit  = (ax >= bx) && (ay >= by) && (ax <= bxw) && (ay <= byh);
    assign block_hit  = (ax >= bx) && (ay >= by) && (axw <= bxw) && (ayh <= byh);

    always_comb
    begin
        case (op_reg) inside
            sot_pkg::OP_CIRC_CIRC, sot_pkg::OP_CIRC_RECT,
            sot_pkg::OP_PT_CIRC, sot_pkg::OP_BLK_CIRC:
                hit_next = circle_hit;
            sot_pkg::OP_RECT_RECT:
                hit_next = rect_hit;
            sot_pkg::OP_PT_RECT:
                hit_next = point_hit;
            sot_pkg::OP_BLK_RECT:
                hit_next = block_hit;
            default:
                hit_next = 1'b0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sot_pkg::OUT_TDATA_W-1){1'b0}}, hit_reg};

endmodule

[sv/sot_checker.sv]
// ----------------------------------------------------------------------------
// Shape overlap tester port checker
// Watches the stream ports of the tester for handshake and flow slips.
// ----------------------------------------------------------------------------
`include "shape_overlap_tester_unit_macros.svh"

module sot_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sot_pkg::OP_W-1:0]        s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sot_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // hold a stalled result beat
    `SOT_ASSERT_NEXT(a_out_valid_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

    `SOT_ASSERT_NEXT(a_out_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "result beat changed while stalled")

    // a ready sink never backs up the input side
    `SOT_ASSERT_NOW(a_no_false_stall, m_tready, s_tready, "input stalled while result side is ready")

    // an unused operation reaches the output as a miss when the sink is ready after it is taken
    `SOT_ASSERT_NEXT(a_unused_op_miss, (s_tvalid && s_tready && s_tuser == sot_pkg::OP_NONE) ##1 m_tready, m_tvalid && !m_tdata[sot_pkg::HIT_BIT], "unused operation did not give a miss")

endmodule

bind shape_overlap_tester_unit sot_checker u_sot_checker (.*);
